FILE: hw/rtl/hrmeb_pkg.sv
// Package for the hit ring map event builder: hit and result types,
// hit word check constants and the board/channel ring table.
// Depends on nothing; used by the hit checker and the top module.
package hrmeb_pkg;

   // Hit word check limits.
   localparam logic [7:0]  HIT_TYPE    = 8'h30;
   localparam logic [7:0]  MAX_CHANNEL = 8'd63;
   localparam logic [15:0] MAX_TOT     = 16'd5000;

   // Reset value of the arrival time tolerance register.
   localparam logic [31:0] TOL_RESET = 32'd200;

   // Configuration register indexes.
   localparam logic REG_TIME_TOLERANCE = 1'b0;

   // Ring number for an unmapped board or channel group.
   localparam logic signed [5:0] RING_NONE = -6'sd1;

   // Ring per board (0..3) and channel group (channel / 8), indexed {board, group}.
   localparam logic signed [5:0] RING_TABLE [32] = '{
      -6'sd1, -6'sd1, -6'sd1, -6'sd1, 6'sd15, 6'sd1,  6'sd16, 6'sd2,
      6'sd17, 6'sd3,  6'sd18, 6'sd4,  6'sd19, 6'sd5,  6'sd20, 6'sd6,
      6'sd21, 6'sd7,  6'sd22, 6'sd8,  6'sd23, 6'sd9,  6'sd24, 6'sd10,
      6'sd25, 6'sd11, 6'sd26, 6'sd12, 6'sd27, 6'sd13, 6'sd28, 6'sd14
   };

   // One input hit as taken from the request channel.
   typedef struct packed {
      logic [9:0]  board_number;
      logic [31:0] hit_word;
      logic [31:0] arrival_time;
   } hit_type;

   // Hit word after checking and unpacking.
   typedef struct packed {
      logic               ok;
      logic [5:0]         channel_number;
      logic [12:0]        over_threshold_time;
      logic signed [5:0]  ring_number;
   } dec_type;

   // One result word.
   typedef struct packed {
      logic               hit_valid;
      logic [5:0]         channel_number;
      logic [12:0]        over_threshold_time;
      logic [31:0]        arrival_echo;
      logic signed [5:0]  ring_number;
      logic [31:0]        event_number;
      logic               store_overflow;
   } res_type;

endpackage

FILE: hw/rtl/hrmeb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies; used for the event arrival time store.
module hrmeb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/hrmeb_check.sv
// Hit word checker: validates type, channel and time-over-threshold,
// unpacks the fields and looks up the ring. Depends on hrmeb_pkg.
module hrmeb_check
   import hrmeb_pkg::*;
(
   input  hit_type hit,
   output dec_type dec
);

   logic [7:0]  hit_kind;
   logic [7:0]  chan;
   logic [15:0] tot;

   assign hit_kind = hit.hit_word[31:24];
   assign chan     = hit.hit_word[23:16];
   assign tot      = hit.hit_word[15:0];

   // Field checks and unpacking.
   always_comb begin
      dec.ok                  = (hit_kind == HIT_TYPE) && (chan <= MAX_CHANNEL)
                                && (tot <= MAX_TOT);
      dec.channel_number      = chan[5:0];
      dec.over_threshold_time = tot[12:0];
      // Boards four and above have no rings.
      if (hit.board_number[9:2] != 8'd0) begin
         dec.ring_number = RING_NONE;
      end else begin
         dec.ring_number = RING_TABLE[{hit.board_number[1:0], chan[5:3]}];
      end
   end

endmodule

FILE: hw/rtl/hit_ring_map_event_builder.sv
// A hit is held in hit_ff, checked, and its result is registered in res_ff and then in the
// output register rsp_ff. A good hit that arrives while an event is open first scans the
// event-time memory, which reads one stored arrival time per cycle on one read port. A new
// hit is taken only once the last result has been moved into the output register.
// Reset (synchronous, active high) empties the event store, clears the event
// number and restores the tolerance to 200; the memory itself is not cleared.
module hit_ring_map_event_builder
   import hrmeb_pkg::*;
#(
   parameter int MAX_EVENT_HITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // Hit input channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: board_number[9:0], hit_word[41:10], arrival_time[73:42], zero fill.
   input  logic [79:0] req_tdata,
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: channel_number[5:0], over_threshold_time[18:6], arrival_echo[50:19],
   // ring_number[56:51], event_number[88:57], store_overflow[89], zero fill.
   output logic [95:0] rsp_tdata,
   // tuser: hit_valid[0].
   output logic        rsp_tuser,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = (MAX_EVENT_HITS > 1) ? $clog2(MAX_EVENT_HITS) : 1;
   localparam int CW = $clog2(MAX_EVENT_HITS + 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_EVENT_HITS);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   logic [1:0]    state_ff, state_in;
   hit_type       hit_ff, hit_in;
   logic [31:0]   tol_ff, tol_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   event_ff, event_in;
   logic          seen_ff, seen_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic          pend_ff, pend_in;
   res_type       res_ff, res_in;
   res_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   dec_type       dec;
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic          ram_re;
   logic [31:0]   ram_rdata;
   logic [31:0]   time_gap;
   logic          near;
   logic          decide;
   logic          join_event;
   logic          overflow;
   logic          csr_write;

   // Hit word check and ring lookup on the held hit.
   hrmeb_check u_check (
      .hit (hit_ff),
      .dec (dec)
   );

   // Arrival times of the current event.
   hrmeb_ram #(
      .WIDTH (32),
      .DEPTH (MAX_EVENT_HITS)
   ) u_times (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (hit_ff.arrival_time),
      .rd_en   (ram_re),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (ram_rdata)
   );

   // Absolute distance between the hit and the stored time just read.
   assign time_gap = (hit_ff.arrival_time >= ram_rdata) ? (hit_ff.arrival_time - ram_rdata)
                                                        : (ram_rdata - hit_ff.arrival_time);
   assign near = (time_gap <= tol_ff);

   // Configuration register access.
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_TIME_TOLERANCE) ? tol_ff : 32'd0;

   // Sequencer: take a hit, check it, scan the store if an event is open, update and emit.
   always_comb begin
      state_in     = state_ff;
      hit_in       = hit_ff;
      tol_in       = tol_ff;
      count_in     = count_ff;
      event_in     = event_ff;
      seen_in      = seen_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_re       = 1'b0;
      decide       = 1'b0;
      join_event   = 1'b0;
      overflow     = 1'b0;

      if (csr_write && (csr_paddr[2] == REG_TIME_TOLERANCE)) begin
         tol_in = csr_pwdata;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               hit_in.board_number = req_tdata[9:0];
               hit_in.hit_word     = req_tdata[41:10];
               hit_in.arrival_time = req_tdata[73:42];
               state_in            = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!dec.ok) begin
               // A bad word only echoes the arrival time and leaves the event store and number alone.
               res_in              = '0;
               res_in.arrival_echo = hit_ff.arrival_time;
               state_in            = S_EMIT;
            end else if (!seen_ff) begin
               decide = 1'b1;
            end else begin
               issue_in = '0;
               pend_in  = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            pend_in = 1'b0;
            if (pend_ff && near) begin
               decide     = 1'b1;
               join_event = 1'b1;
            end else if (issue_ff < count_ff) begin
               ram_re   = 1'b1;
               issue_in = issue_ff + 1'b1;
               pend_in  = 1'b1;
            end else begin
               decide = 1'b1;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Event update: append to the current event (flagging overflow when full) or open the next one.
      if (decide) begin
         if (join_event) begin
            if (count_ff < COUNT_MAX) begin
               ram_we    = 1'b1;
               ram_waddr = count_ff[AW-1:0];
               count_in  = count_ff + 1'b1;
            end else begin
               overflow = 1'b1;
            end
         end else begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            count_in  = CW'(1);
            event_in  = event_ff + 32'd1;
            seen_in   = 1'b1;
         end
         res_in.hit_valid           = 1'b1;
         res_in.channel_number      = dec.channel_number;
         res_in.over_threshold_time = dec.over_threshold_time;
         res_in.arrival_echo        = hit_ff.arrival_time;
         res_in.ring_number         = dec.ring_number;
         res_in.event_number        = event_in;
         res_in.store_overflow      = overflow;
         state_in                   = S_EMIT;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tol_ff       <= TOL_RESET;
         count_ff     <= '0;
         event_ff     <= '0;
         seen_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tol_ff       <= tol_in;
         count_ff     <= count_in;
         event_ff     <= event_in;
         seen_ff      <= seen_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      hit_ff   <= hit_in;
      issue_ff <= issue_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.hit_valid;
   assign rsp_tdata  = {6'd0, rsp_ff.store_overflow, rsp_ff.event_number,
                        rsp_ff.ring_number, rsp_ff.arrival_echo,
                        rsp_ff.over_threshold_time, rsp_ff.channel_number};

`ifndef SYNTHESIS
   // The store never holds more times than it has entries.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("event store count exceeds its depth");

   // The scan never reads past the filled part of the store.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> issue_ff <= count_ff)
      else $error("scan index beyond stored count");

   // Once an event is open, its store holds at least the opening hit.
   a_open_nonempty: assert property (@(posedge clock) disable iff (reset)
      seen_ff |-> count_ff != '0)
      else $error("open event with empty store");

   // A compare is only made on data read in the previous cycle.
   a_read_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && pend_ff) |-> $past(ram_re))
      else $error("compare without a preceding memory read");

   // A rejected hit carries no event number and no overflow flag.
   a_bad_hit_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.hit_valid) |->
         (rsp_ff.event_number == 32'd0 && !rsp_ff.store_overflow))
      else $error("rejected hit carries event data");
`endif

endmodule
